/* src/positional_ordered_list_unit_assert.svh */
// assertion macros for the positional ordered list unit
// no dependencies; included by the modules that carry assertions
`ifndef POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is high
`define POL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also active during reset
`define POL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define POL_ASSERT(lbl, clk, rst, prop, msg)
`define POL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* src/pol_pkg.sv */
// shared constants, codes and types of the positional ordered list unit
// no dependencies
package pol_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int LEN_W = 5;
  localparam int ST_W = 2;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_DELETE   = 3'd3,
    CMD_READ     = 3'd4
  } cmd_code_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [IDX_W-1:0]       k;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

/* src/pol_cmd_if.sv */
// command channel of the positional ordered list unit
// depends on pol_pkg
interface pol_cmd_if;
  import pol_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] item_value;
  logic [POS_W-1:0]        position;

  modport source (output valid, cmd, item_value, position, input ready);
  modport sink (input valid, cmd, item_value, position, output ready);
endinterface

/* src/pol_rsp_if.sv */
// result channel of the positional ordered list unit
// depends on pol_pkg
interface pol_rsp_if;
  import pol_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [LEN_W-1:0]        list_length;
  logic [ST_W-1:0]         status;

  modport source (output valid, read_value, list_length, status, input ready);
  modport sink (input valid, read_value, list_length, status, output ready);
endinterface

/* src/pol_cell.sv */
// one storage cell of the list chain: holds, loads, or takes a neighbor value
// depends on pol_pkg
module pol_cell (
  input  logic                            clk,
  input  pol_pkg::cell_ctl_t              ctl,
  input  logic [pol_pkg::IDX_W-1:0]       index,
  input  logic signed [pol_pkg::VAL_W-1:0] prev_value,
  input  logic signed [pol_pkg::VAL_W-1:0] next_value,
  output logic signed [pol_pkg::VAL_W-1:0] value
);
  import pol_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_INSERT: begin
        if (index == ctl.k) begin
          value <= ctl.value;
        end else if (index > ctl.k) begin
          value <= prev_value;
        end
      end
      CELL_DELETE: begin
        if (index >= ctl.k) begin
          value <= next_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/pol_ctl.sv */
// command decode, element count and result register of the list unit
// depends on pol_pkg, pol_cmd_if, pol_rsp_if and the assertion macros
`include "positional_ordered_list_unit_assert.svh"

module pol_ctl (
  input  logic                            clk,
  input  logic                            rst,
  pol_cmd_if.sink                         cmd_ch,
  pol_rsp_if.source                       rsp_ch,
  input  logic signed [pol_pkg::VAL_W-1:0] read_data,
  output pol_pkg::cell_ctl_t              cell_ctl
);
  import pol_pkg::*;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  status_t                 status_next;
  logic signed [VAL_W-1:0] read_next;
  cell_op_t                op;
  logic [IDX_W-1:0]        k;
  logic                    fire;
  logic                    full;
  logic                    pos_zero;
  logic                    pos_above;
  logic                    is_insert;
  logic [IDX_W-1:0]        k_pos;
  logic [IDX_W-1:0]        k_tail;

  assign cmd_ch.ready = !rst && (!rsp_ch.valid || rsp_ch.ready);
  assign fire = cmd_ch.valid && cmd_ch.ready;

  assign full = (count == CNT_W'(DEPTH));
  assign pos_zero = (cmd_ch.position == '0);
  assign pos_above = (CMP_W'(cmd_ch.position) > CMP_W'(count));
  assign k_pos = IDX_W'(cmd_ch.position - POS_W'(1));
  assign k_tail = IDX_W'(count);
  assign is_insert = (cmd_ch.cmd == CMD_INS_HEAD) || (cmd_ch.cmd == CMD_INS_TAIL)
                  || (cmd_ch.cmd == CMD_INS_POS);

  always_comb begin
    op = CELL_HOLD;
    k = k_pos;
    count_next = count;
    status_next = ST_OK;
    read_next = '0;
    unique case (cmd_code_t'(cmd_ch.cmd))
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (cmd_ch.cmd == CMD_INS_HEAD) begin
          op = CELL_INSERT;
          k = '0;
          count_next = count + CNT_W'(1);
        end else if (cmd_ch.cmd == CMD_INS_TAIL || count == '0 || pos_above) begin
          op = CELL_INSERT;
          k = k_tail;
          count_next = count + CNT_W'(1);
        end else if (pos_zero) begin
          status_next = ST_BADPOS;
        end else begin
          op = CELL_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (pos_zero || pos_above) begin
          status_next = ST_BADPOS;
        end else begin
          op = CELL_DELETE;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_zero || pos_above) begin
          status_next = ST_BADPOS;
        end else begin
          read_next = read_data;
        end
      end
      default: begin
      end
    endcase
  end

  assign cell_ctl.op = fire ? op : CELL_HOLD;
  assign cell_ctl.k = k;
  assign cell_ctl.value = cmd_ch.item_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rsp_ch.valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
        rsp_ch.valid <= 1'b1;
      end else if (rsp_ch.ready) begin
        rsp_ch.valid <= 1'b0;
      end
    end
    if (fire) begin
      rsp_ch.read_value <= read_next;
      rsp_ch.list_length <= LEN_W'(count_next);
      rsp_ch.status <= status_next;
    end
  end

  `POL_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "count above depth")
  `POL_ASSERT(a_fire_valid, clk, rst, fire |=> rsp_ch.valid, "transfer gave no result")
  `POL_ASSERT(a_len_match, clk, rst, fire |=> rsp_ch.list_length == LEN_W'(count), "length mismatch")
  `POL_ASSERT(a_full_hold, clk, rst, (fire && status_next == ST_FULL) |=> $stable(count), "full insert changed count")
  `POL_ASSERT(a_ins_grow, clk, rst, (fire && is_insert && status_next == ST_OK) |=> count == CNT_W'($past(count) + CNT_W'(1)), "insert did not grow list")

endmodule

/* src/positional_ordered_list_unit.sv */
// positional ordered list unit: bounded ordered list of signed 32-bit values
// depends on pol_pkg, pol_cmd_if, pol_rsp_if, pol_cell and pol_ctl
//
// cmd_ch carries one command per transfer: insert at head, insert at tail,
// insert at a 1-based position, delete at a position, or read at a position.
// rsp_ch returns exactly one result per command: the value read (zero unless
// a good read), the list length after the command, and a status code.
// Storage is a row of DEPTH cells; element p lives in cell p-1. An insert
// loads the target cell and makes the cells past it take their left neighbor,
// a delete makes the cells at and past the target take their right neighbor,
// all on the same clock edge.
// The result is registered and appears in the cycle after the command transfer.
// One command is taken per cycle as long as no result is stalled.
// A stalled result sits in the output register; outside reset cmd_ch.ready
// stays low only while that register is full and rsp_ch.ready is low.
// Reset empties the list and drops any pending result; cmd_ch.ready is low
// while rst is high.
module positional_ordered_list_unit (
  input  logic       clk,
  input  logic       rst,
  pol_cmd_if.sink    cmd_ch,
  pol_rsp_if.source  rsp_ch
);
  import pol_pkg::*;

  cell_ctl_t               cell_ctl;
  logic signed [VAL_W-1:0] cell_value [DEPTH];
  logic signed [VAL_W-1:0] cell_prev [DEPTH];
  logic signed [VAL_W-1:0] cell_next [DEPTH];
  logic signed [VAL_W-1:0] read_data;

  assign read_data = cell_value[cell_ctl.k];

  pol_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_ch),
    .rsp_ch    (rsp_ch),
    .read_data (read_data),
    .cell_ctl  (cell_ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_prev[i] = cell_ctl.value;
    end else begin : g_prev
      assign cell_prev[i] = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign cell_next[i] = '0;
    end else begin : g_next
      assign cell_next[i] = cell_value[i+1];
    end

    pol_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .index      (IDX_W'(i)),
      .prev_value (cell_prev[i]),
      .next_value (cell_next[i]),
      .value      (cell_value[i])
    );
  end

endmodule

/* tb/tb_positional_ordered_list_unit.sv */
`timescale 1ns / 100ps
// testbench for positional_ordered_list_unit: directed and random list commands,
// results predicted by a shadow list in a scoreboard; needs pol_pkg and the channel ifs
module tb_positional_ordered_list_unit;
  import pol_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_PER_PHASE = 270;
  localparam int NUM_PHASES = 4;
  localparam int POS_MAX = (1 << POS_W) - 1;
  localparam int CMD_MAX = (1 << CMD_W) - 1;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        list_length;
    logic [ST_W-1:0]         status;
  } list_result_t;

  class list_scoreboard;
    logic signed [VAL_W-1:0] cells [DEPTH];
    int count;
    list_result_t pending_q[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    task report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
      errors++;
    endtask

    // shadow list update for one accepted command
    function void note_command(logic [CMD_W-1:0] op, logic signed [VAL_W-1:0] v,
                               logic [POS_W-1:0] p);
      list_result_t r;
      int slot;
      int i;
      r.read_value = '0;
      r.status = ST_OK;
      case (op)
        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            if (op == CMD_INS_HEAD) slot = 0;
            else if (op == CMD_INS_TAIL || count == 0 || p > count) slot = count;
            else if (p == 0) slot = -1;
            else slot = p - 1;
            if (slot < 0) begin
              r.status = ST_BADPOS;
            end else begin
              for (i = count; i > slot; i--) cells[i] = cells[i-1];
              cells[slot] = v;
              count++;
            end
          end
        end
        CMD_DELETE: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else if (p == 0 || p > count) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = p - 1; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        CMD_READ: begin
          if (p == 0 || p > count) r.status = ST_BADPOS;
          else r.read_value = cells[p-1];
        end
        default: ;
      endcase
      r.list_length = LEN_W'(count);
      pending_q.push_back(r);
    endfunction

    task check_result(logic signed [VAL_W-1:0] rv, logic [LEN_W-1:0] len,
                      logic [ST_W-1:0] st);
      list_result_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result", rv, '0);
      end else begin
        want = pending_q.pop_front();
        if (rv !== want.read_value) report("read_value", rv, want.read_value);
        if (len !== want.list_length)
          report("list_length", VAL_W'(len), VAL_W'(want.list_length));
        if (st !== want.status) report("status", VAL_W'(st), VAL_W'(want.status));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int idle_pct;
  int stall_pct;
  int cycle_count;
  int send_idle [NUM_PHASES] = '{0, 64, 0, 34};
  int recv_stall [NUM_PHASES] = '{0, 0, 64, 34};
  list_scoreboard sb = new();

  pol_cmd_if cmd_ch ();
  pol_rsp_if rsp_ch ();

  positional_ordered_list_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .rsp_ch (rsp_ch)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready)
        sb.note_command(cmd_ch.cmd, cmd_ch.item_value, cmd_ch.position);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.read_value, rsp_ch.list_length, rsp_ch.status);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task send(input logic [CMD_W-1:0] op, input logic signed [VAL_W-1:0] v,
            input logic [POS_W-1:0] p);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.cmd <= CMD_W'($urandom);
      cmd_ch.item_value <= $urandom;
      cmd_ch.position <= POS_W'($urandom);
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= op;
    cmd_ch.item_value <= v;
    cmd_ch.position <= p;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  task drain;
    cmd_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task send_directed;
    int k;
    send(CMD_READ, VAL_MAX, POS_W'(1));
    send(CMD_DELETE, VAL_MAX, POS_W'(1));
    send(CMD_INS_POS, VAL_MAX, POS_W'(0));
    send(CMD_INS_HEAD, VAL_MIN, POS_W'(1));
    send(CMD_INS_TAIL, '0, POS_W'(0));
    send(CMD_INS_POS, -1, POS_W'(0));
    send(CMD_INS_POS, -1, POS_W'(2));
    send(CMD_INS_POS, 32'h5555_5555, POS_W'(POS_MAX));
    send(CMD_READ, '0, POS_W'(0));
    send(CMD_READ, '0, POS_W'(DEPTH + 1));
    send(CMD_DELETE, '0, POS_W'(0));
    send(CMD_DELETE, '0, POS_W'(POS_MAX));
    for (k = int'(CMD_READ) + 1; k <= CMD_MAX; k++) send(k[CMD_W-1:0], VAL_MAX, POS_W'(1));
    while (sb.count < DEPTH) send(CMD_INS_TAIL, $urandom, POS_W'($urandom));
    send(CMD_INS_HEAD, VAL_MAX, POS_W'(1));
    send(CMD_INS_POS, VAL_MIN, POS_W'(3));
    send(CMD_INS_TAIL, -1, POS_W'(0));
    send(CMD_READ, '0, POS_W'(DEPTH));
    send(CMD_DELETE, '0, POS_W'(DEPTH));
    send(CMD_DELETE, '0, POS_W'(1));
    send(CMD_READ, '0, POS_W'(1));
  endtask

  task send_random(input int n);
    int k;
    int roll;
    int span;
    bit filling;
    logic [CMD_W-1:0] op;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0] p;
    filling = 1'b1;
    for (k = 0; k < n; k++) begin
      if (sb.count == DEPTH) filling = 1'b0;
      else if (sb.count == 0) filling = 1'b1;
      else if ($urandom_range(29) == 0) filling = !filling;
      roll = $urandom_range(99);
      if (roll < 3) op = CMD_W'($urandom_range(CMD_MAX, int'(CMD_READ) + 1));
      else if (roll < 23) op = CMD_READ;
      else if (filling ? roll < 33 : roll < 73) op = CMD_DELETE;
      else begin
        case ($urandom_range(2))
          0: op = CMD_INS_HEAD;
          1: op = CMD_INS_TAIL;
          default: op = CMD_INS_POS;
        endcase
      end
      span = (sb.count == 0) ? 1 : sb.count;
      roll = $urandom_range(99);
      if (roll < 80) p = POS_W'($urandom_range(span + 1, 1));
      else if (roll < 88) p = '0;
      else p = POS_W'($urandom_range(POS_MAX));
      case ($urandom_range(9))
        0: v = VAL_MIN;
        1: v = VAL_MAX;
        2: v = '0;
        3: v = -1;
        default: v = $urandom;
      endcase
      send(op, v, p);
    end
  endtask

  initial begin
    int ph;
    clk = 1'b0;
    rst = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = '0;
    cmd_ch.item_value = '0;
    cmd_ch.position = '0;
    rsp_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_directed();
    drain();
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct = send_idle[ph];
      stall_pct = recv_stall[ph];
      send_random(RANDOM_PER_PHASE);
      drain();
    end
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* positional_ordered_list_unit.f */
+incdir+src
src/pol_pkg.sv
src/pol_cmd_if.sv
src/pol_rsp_if.sv
src/pol_cell.sv
src/pol_ctl.sv
src/positional_ordered_list_unit.sv
tb/tb_positional_ordered_list_unit.sv
